FILE: rtl/lsef_pkg.sv
// lsef_pkg: constants, types and the log2 table of the local entropy filter
// used by every module of the block; depends on nothing
package lsef_pkg;

    localparam int HALF_WINDOW = 3;
    localparam int MAX_WIDTH   = 2048;
    localparam int FRAC_BITS   = 12;

    localparam int SPAN   = 2 * HALF_WINDOW;
    localparam int LINES  = SPAN - 1;
    localparam int AREA   = SPAN * SPAN;
    localparam int PIX_W  = 8;
    localparam int DIM_W  = 12;
    localparam int ROW_W  = 12;
    localparam int OCOL_W = 11;
    localparam int ENT_W  = 15;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EW_W   = (DIM_W > $clog2(MAX_WIDTH + 1)) ? DIM_W : $clog2(MAX_WIDTH + 1);
    localparam int BANK_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CNT_W  = $clog2(AREA + 1);
    localparam int AIDX_W = $clog2(AREA);
    localparam int LOG_W  = 36;
    localparam int ACC_W  = LOG_W + CNT_W;
    localparam int SHIFT  = 32 - FRAC_BITS;
    localparam int Y_W    = ACC_W + 1 - SHIFT;

    // reciprocal of the window area, exact for every Y_W-bit dividend
    localparam int RCP_S  = Y_W + CNT_W;
    localparam int RCP_W  = RCP_S;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((64'd1 << RCP_S) + 64'(AREA) - 64'd1) / 64'(AREA));

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [SPAN-1:0][SPAN-1:0][PIX_W-1:0] t_win;
    typedef logic [AREA-1:0][PIX_W-1:0]           t_flat;

    typedef struct packed {
        t_flat              win;
        logic [ROW_W-1:0]   row;
        logic [OCOL_W-1:0]  col;
    } t_item;

    typedef logic [LOG_W-1:0] t_log_tbl [AREA+1];

    // log2 with 32 fraction bits, mantissa squaring
    function automatic logic [63:0] log2_q32(input int unsigned c);
        int unsigned k;
        logic [63:0] m;
        logic [63:0] frac;
        k = 0;
        frac = '0;
        while (k < 31 && (c >> (k + 1)) != 0)
            k++;
        m = (64'(c) << 31) >> k;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(k) << 32) | frac;
    endfunction

    function automatic t_log_tbl build_log_tbl();
        t_log_tbl t;
        t[0] = '0;
        for (int c = 1; c <= AREA; c++)
            t[c] = LOG_W'(log2_q32(c));
        return t;
    endfunction

    localparam t_log_tbl LOG_TBL = build_log_tbl();

    // full-window term area*log2(area) and half the divisor for rounding
    localparam logic [ACC_W-1:0] TOP_SUM = ACC_W'(AREA) * ACC_W'(LOG_TBL[AREA]);
    localparam logic [ACC_W:0]   HALF_D  = (ACC_W+1)'(AREA) << (SHIFT - 1);

endpackage

FILE: rtl/lsef_if.sv
// lsef_if: valid/ready channels of the entropy filter (pixel, result, config)
// widths from lsef_pkg
interface lsef_pix_if;
    logic                       valid;
    logic                       ready;
    logic [lsef_pkg::PIX_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lsef_res_if;
    logic                        valid;
    logic                        ready;
    logic [lsef_pkg::ENT_W-1:0]  entropy;
    logic [lsef_pkg::ROW_W-1:0]  out_row;
    logic [lsef_pkg::OCOL_W-1:0] out_col;
    modport source (output valid, output entropy, output out_row, output out_col, input ready);
    modport sink   (input valid, input entropy, input out_row, input out_col, output ready);
endinterface

interface lsef_cfg_if;
    logic                       valid;
    logic                       ready;
    lsef_pkg::t_cfg_reg         index;
    logic [lsef_pkg::DIM_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/lsef_ram.sv
// lsef_ram: generic single-write, single-read RAM with registered read
// no dependencies
module lsef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/lsef_front.sv
// lsef_front: pixel intake, line buffers, window shift and interior check
// uses lsef_pkg, lsef_ram, lsef_pix_if, lsef_cfg_if
module lsef_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lsef_pix_if.sink            i_pix,
    lsef_cfg_if.sink            i_cfg,
    output logic                o_push,
    input  logic                i_push_ready,
    output lsef_pkg::t_item     o_item
);
    typedef enum logic [1:0] {F_IDLE, F_SHIFT, F_PUSH} t_fstate;

    t_fstate                      r_state;
    logic [lsef_pkg::DIM_W-1:0]   r_width, r_height;
    logic [lsef_pkg::COL_W-1:0]   r_col;
    logic [lsef_pkg::ROW_W-1:0]   r_row;
    logic [lsef_pkg::BANK_W-1:0]  r_bank;
    logic [lsef_pkg::PIX_W-1:0]   r_px;
    lsef_pkg::t_win               r_win;
    logic [lsef_pkg::ROW_W-1:0]   r_orow;
    logic [lsef_pkg::OCOL_W-1:0]  r_ocol;
    logic [lsef_pkg::PIX_W-1:0]   rdata [lsef_pkg::LINES];
    logic [lsef_pkg::EW_W-1:0]    effw;
    logic [lsef_pkg::DIM_W-1:0]   effh;
    logic                         col_wrap, row_wrap, emit;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == F_IDLE);

    for (genvar b = 0; b < lsef_pkg::LINES; b++) begin : g_line
        lsef_ram #(.WIDTH(lsef_pkg::PIX_W), .DEPTH(lsef_pkg::MAX_WIDTH)) u_line (
            .i_clk   (i_clk),
            .i_we    (r_state == F_SHIFT && r_bank == lsef_pkg::BANK_W'(b)),
            .i_waddr (r_col),
            .i_wdata (r_px),
            .i_raddr (r_col),
            .o_rdata (rdata[b])
        );
    end

    always_comb begin
        if (r_width == '0) begin
            effw = lsef_pkg::EW_W'(1);
        end else if (lsef_pkg::EW_W'(r_width) > lsef_pkg::EW_W'(lsef_pkg::MAX_WIDTH)) begin
            effw = lsef_pkg::EW_W'(lsef_pkg::MAX_WIDTH);
        end else begin
            effw = lsef_pkg::EW_W'(r_width);
        end
        effh = (r_height == '0) ? lsef_pkg::DIM_W'(1) : r_height;
        col_wrap = ((lsef_pkg::EW_W+1)'(r_col) + 1'b1) >= (lsef_pkg::EW_W+1)'(effw);
        row_wrap = ((lsef_pkg::ROW_W+1)'(r_row) + 1'b1) >= (lsef_pkg::ROW_W+1)'(effh);
        emit = (r_row >= lsef_pkg::ROW_W'(lsef_pkg::LINES))
            && ((lsef_pkg::EW_W+1)'(r_col) >= (lsef_pkg::EW_W+1)'(lsef_pkg::LINES))
            && (((lsef_pkg::ROW_W+1)'(r_row) + 2'd2) <= (lsef_pkg::ROW_W+1)'(effh))
            && (((lsef_pkg::EW_W+1)'(r_col) + 2'd2) <= (lsef_pkg::EW_W+1)'(effw));
    end

    assign o_push      = (r_state == F_PUSH);
    assign o_item.win  = r_win;
    assign o_item.row  = r_orow;
    assign o_item.col  = r_ocol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_width  <= lsef_pkg::WIDTH_RESET;
            r_height <= lsef_pkg::HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_bank   <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    lsef_pkg::REG_WIDTH:  r_width  <= i_cfg.data;
                    lsef_pkg::REG_HEIGHT: r_height <= i_cfg.data;
                endcase
            end
            unique case (r_state)
                F_IDLE: begin
                    if (i_pix.valid) begin
                        r_px    <= i_pix.pixel;
                        r_state <= F_SHIFT;
                    end
                end
                F_SHIFT: begin
                    // window row order inside a column does not matter to the histogram
                    for (int c = 0; c < lsef_pkg::SPAN - 1; c++)
                        r_win[c] <= r_win[c+1];
                    for (int r = 0; r < lsef_pkg::LINES; r++)
                        r_win[lsef_pkg::SPAN-1][r] <= rdata[r];
                    r_win[lsef_pkg::SPAN-1][lsef_pkg::SPAN-1] <= r_px;
                    r_orow <= lsef_pkg::ROW_W'(r_row - lsef_pkg::ROW_W'(lsef_pkg::HALF_WINDOW - 1));
                    r_ocol <= lsef_pkg::OCOL_W'(r_col - lsef_pkg::COL_W'(lsef_pkg::HALF_WINDOW - 1));
                    if (col_wrap) begin
                        r_col <= '0;
                        if (row_wrap) begin
                            r_row  <= '0;
                            r_bank <= '0;
                        end else begin
                            r_row  <= r_row + 1'b1;
                            r_bank <= (r_bank == lsef_pkg::BANK_W'(lsef_pkg::LINES - 1))
                                    ? '0 : r_bank + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= emit ? F_PUSH : F_IDLE;
                end
                F_PUSH: begin
                    if (i_push_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/lsef_queue.sv
// lsef_queue: two-entry queue of windows between intake and entropy unit
// uses lsef_pkg
module lsef_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  lsef_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_pop,
    output lsef_pkg::t_item  o_item
);
    lsef_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            do_push, do_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

FILE: rtl/lsef_back.sv
// lsef_back: window entropy from per-pixel value counts, rounding, divide by area
// uses lsef_pkg, lsef_res_if
module lsef_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_pop,
    input  lsef_pkg::t_item  i_item,
    lsef_res_if.source       o_res
);
    typedef enum logic [2:0] {B_IDLE, B_HIST, B_ROUND, B_DIV, B_OUT} t_bstate;

    t_bstate                      r_state;
    lsef_pkg::t_flat              r_win;
    logic [lsef_pkg::ROW_W-1:0]   r_row;
    logic [lsef_pkg::OCOL_W-1:0]  r_col;
    logic [lsef_pkg::AIDX_W-1:0]  r_i;
    logic [lsef_pkg::ACC_W-1:0]   r_acc;
    logic [lsef_pkg::Y_W-1:0]     r_y, r_q;
    logic                         r_ovalid;
    logic [lsef_pkg::ENT_W-1:0]   r_ent;
    logic [lsef_pkg::ROW_W-1:0]   r_orow;
    logic [lsef_pkg::OCOL_W-1:0]  r_ocol;
    logic [lsef_pkg::AREA-1:0]    match;
    logic [lsef_pkg::CNT_W-1:0]   cnt;
    logic [lsef_pkg::ACC_W:0]     num;
    logic [lsef_pkg::Y_W+lsef_pkg::RCP_W-1:0] prod;

    // sum of count*log2(count) over bins equals sum over pixels of log2(own count)
    always_comb begin
        for (int j = 0; j < lsef_pkg::AREA; j++)
            match[j] = (r_win[j] == r_win[r_i]);
        cnt   = lsef_pkg::CNT_W'($countones(match));
        num   = (lsef_pkg::ACC_W+1)'(lsef_pkg::TOP_SUM) - (lsef_pkg::ACC_W+1)'(r_acc)
              + lsef_pkg::HALF_D;
        prod  = (lsef_pkg::Y_W+lsef_pkg::RCP_W)'(r_y)
              * (lsef_pkg::Y_W+lsef_pkg::RCP_W)'(lsef_pkg::RCP_M);
    end

    assign o_pop         = (r_state == B_IDLE);
    assign o_res.valid   = r_ovalid;
    assign o_res.entropy = r_ent;
    assign o_res.out_row = r_orow;
    assign o_res.out_col = r_ocol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_res.ready && r_state != B_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_win   <= i_item.win;
                        r_row   <= i_item.row;
                        r_col   <= i_item.col;
                        r_i     <= '0;
                        r_acc   <= '0;
                        r_state <= B_HIST;
                    end
                end
                B_HIST: begin
                    r_acc <= r_acc + lsef_pkg::ACC_W'(lsef_pkg::LOG_TBL[cnt]);
                    r_i   <= r_i + 1'b1;
                    if (r_i == lsef_pkg::AIDX_W'(lsef_pkg::AREA - 1)) begin
                        r_state <= B_ROUND;
                    end
                end
                B_ROUND: begin
                    // all pixels equal gives a non-positive numerator
                    if (r_acc >= lsef_pkg::TOP_SUM) begin
                        r_y <= '0;
                    end else begin
                        r_y <= lsef_pkg::Y_W'(num >> lsef_pkg::SHIFT);
                    end
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    // divide by the window area through its reciprocal
                    r_q     <= lsef_pkg::Y_W'(prod >> lsef_pkg::RCP_S);
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_ent    <= (r_q > lsef_pkg::Y_W'({lsef_pkg::ENT_W{1'b1}}))
                                  ? {lsef_pkg::ENT_W{1'b1}} : lsef_pkg::ENT_W'(r_q);
                        r_orow   <= r_row;
                        r_ocol   <= r_col;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/local_shannon_entropy_filter_unit.sv
// Local Shannon entropy filter over a 6x6 window of 8-bit grey pixels in raster order,
// returning unsigned Q3.12 entropy with the row and column of the interior pixel it
// belongs to; border pixels give no word. The intake handles each pixel by a line
// buffer read, then window shift and write-back, then a push state when its window is
// queued, which stalls while the queue is full. Each interior window then passes the
// entropy unit's count loop over the 36 window pixels, a rounding step, a
// reciprocal multiply by the window area and an output step; a two-entry queue lets
// the intake run ahead meanwhile.
// Line buffers are not cleared; widths and heights take effect as written.
// Depends on lsef_pkg, lsef_if, lsef_front, lsef_queue, lsef_back.
module local_shannon_entropy_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsef_pix_if.sink    i_pix,
    lsef_cfg_if.sink    i_cfg,
    lsef_res_if.source  o_res
);
    logic             push, push_ready, q_valid, pop;
    lsef_pkg::t_item  f_item, q_item;

    lsef_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (i_pix),
        .i_cfg        (i_cfg),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_item       (f_item)
    );

    lsef_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_item       (f_item),
        .o_valid      (q_valid),
        .i_pop        (pop),
        .o_item       (q_item)
    );

    lsef_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (pop),
        .i_item  (q_item),
        .o_res   (o_res)
    );
endmodule
